[hw/rtl/rqhs_pkg.sv]
// shared types, constants and codes for the ring queue with heap sort
package rqhs_pkg;

   localparam int CAPACITY_DEF  = 1024;
   localparam int TAG_WIDTH_DEF = 16;
   localparam int PRIO_WIDTH    = 4;
   localparam int OCC_WIDTH     = 11;

   localparam logic [1:0] ACT_PUSH = 2'd0;
   localparam logic [1:0] ACT_POP  = 2'd1;
   localparam logic [1:0] ACT_SORT = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0]              action;
      logic [PRIO_WIDTH-1:0]   entry_priority;
      logic [TAG_WIDTH_DEF-1:0] entry_tag;
   } req_type;

   typedef struct packed {
      logic [1:0]              status;
      logic [PRIO_WIDTH-1:0]   out_priority;
      logic [TAG_WIDTH_DEF-1:0] out_tag;
      logic [OCC_WIDTH-1:0]    occupancy;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_BUILD,
      S_RD_NODE,
      S_RD_LEFT,
      S_RD_RIGHT,
      S_DECIDE,
      S_SWAP_WR,
      S_EXTRACT,
      S_EX_RD,
      S_EX_WR,
      S_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;      // accept request, perform push or pop
      logic sort_init;   // start sort: n and i set up
      logic load_root;   // set cur node from sift start
      logic rd_node;
      logic rd_left;
      logic rd_right;
      logic decide;      // pick largest, latch swap target
      logic swap_wr;     // write pair and descend
      logic build_next;  // next build start
      logic ex_root;     // read root before an extract
      logic ex_rd;       // read last, keep root
      logic ex_wr;       // swap root with last, shrink heap
      logic rsp_load;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic is_sort;
      logic sort_trivial;
      logic build_done;
      logic extract_done;
      logic has_left;
      logic has_right;
      logic need_swap;
      logic rsp_busy;
   } sts_type;

endpackage

[hw/rtl/rqhs_ctrl.sv]
// controller state machine for the ring queue with heap sort
module rqhs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rqhs_pkg::sts_type sts,
   output rqhs_pkg::ctl_type ctl
);
   import rqhs_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = sts.rsp_busy;
            if (req_valid && !sts.rsp_busy) begin
               ctl.accept = 1'b1;
               if (sts.is_sort) begin
                  if (sts.sort_trivial) begin
                     state_in = S_RESP;
                  end else begin
                     ctl.sort_init = 1'b1;
                     state_in = S_BUILD;
                  end
               end else begin
                  ctl.rsp_load = 1'b1;
               end
            end
         end
         S_BUILD: begin
            ctl.load_root = 1'b1;
            state_in = S_RD_NODE;
         end
         S_RD_NODE: begin
            ctl.rd_node = 1'b1;
            state_in = sts.has_left ? S_RD_LEFT : S_DECIDE;
         end
         S_RD_LEFT: begin
            ctl.rd_left = 1'b1;
            state_in = sts.has_right ? S_RD_RIGHT : S_DECIDE;
         end
         S_RD_RIGHT: begin
            ctl.rd_right = 1'b1;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            ctl.decide = 1'b1;
            if (sts.need_swap) begin
               state_in = S_SWAP_WR;
            end else if (!sts.build_done) begin
               ctl.build_next = 1'b1;
               state_in = S_BUILD;
            end else begin
               state_in = S_EXTRACT;
            end
         end
         S_SWAP_WR: begin
            ctl.swap_wr = 1'b1;
            state_in = S_RD_NODE;
         end
         S_EXTRACT: begin
            if (sts.extract_done) begin
               state_in = S_RESP;
            end else begin
               ctl.ex_root = 1'b1;
               state_in = S_EX_RD;
            end
         end
         S_EX_RD: begin
            ctl.ex_rd = 1'b1;
            state_in = S_EX_WR;
         end
         S_EX_WR: begin
            ctl.ex_wr = 1'b1;
            state_in = S_RD_NODE;
         end
         S_RESP: begin
            if (!sts.rsp_busy) begin
               ctl.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

[hw/rtl/rqhs_dp.sv]
// datapath: entry memory, ring pointers, heap sift unit and result register
module rqhs_dp #(
   parameter int CAPACITY  = rqhs_pkg::CAPACITY_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  rqhs_pkg::req_type req_data,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output rqhs_pkg::rsp_type rsp_data,
   input  rqhs_pkg::ctl_type ctl,
   output rqhs_pkg::sts_type sts
);
   import rqhs_pkg::*;

   localparam int TAG_WIDTH = TAG_WIDTH_DEF;
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = CW + 1;  // wide enough for 2*i+2
   localparam int EW = PRIO_WIDTH + TAG_WIDTH;

   logic [EW-1:0] mem [CAPACITY];
   logic [EW-1:0] rd_q;
   logic [EW-1:0] rd_v;

   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] n_ff, n_in;       // heap size
   logic [CW-1:0] bi_ff, bi_in;     // build index (start+1)
   logic [CW-1:0] cur_ff, cur_in;   // sifting node
   logic [CW-1:0] tgt_ff, tgt_in;   // chosen child
   logic          build_ff, build_in;
   logic [EW-1:0] node_ff, left_ff, right_ff, tgte_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff;
   logic          pop_pend_ff;
   logic          fwd_ff;
   logic [EW-1:0] fwd_data_ff;

   logic [PW-1:0] lpos, rpos;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [EW-1:0] wr_data;
   logic          rd_en, wr_en;
   logic [EW-1:0] node_v, left_v, pick_e;
   logic [CW-1:0] pick_p;

   // ring position to memory slot; positions never exceed the capacity
   function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] p);
      logic [CW:0] s;
      s = (CW+1)'(h) + (CW+1)'(p);
      if (s >= (CW+1)'(CAPACITY)) s = s - (CW+1)'(CAPACITY);
      return s[AW-1:0];
   endfunction

   assign lpos = {cur_ff, 1'b1};
   assign rpos = {cur_ff, 1'b0} + PW'(2);

   // read data of previous-cycle read arrives in rd_q; use it where just read
   // reads: rd_node -> node, rd_left -> left, rd_right -> right
   logic [1:0] rsel_ff;
   always_comb begin
      rd_en   = ctl.rd_node | ctl.rd_left | ctl.rd_right | ctl.ex_root | ctl.ex_rd |
                (ctl.accept && req_data.action == ACT_POP);
      rd_addr = slot(head_ff, '0);
      if (ctl.rd_node)  rd_addr = slot(head_ff, cur_ff);
      if (ctl.rd_left)  rd_addr = slot(head_ff, lpos[CW-1:0]);
      if (ctl.rd_right) rd_addr = slot(head_ff, rpos[CW-1:0]);
      if (ctl.ex_rd)    rd_addr = slot(head_ff, n_ff - CW'(1));
   end

   // rd_q then latched into a named register in the following state
   always_ff @(posedge clock) begin
      if (rd_en) rd_q <= mem[rd_addr];
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   // a read of the slot being written returns the new entry
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else begin
         fwd_ff <= rd_en && wr_en && (rd_addr == wr_addr);
      end
      fwd_data_ff <= wr_data;
   end

   assign rd_v = fwd_ff ? fwd_data_ff : rd_q;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsel_ff <= 2'd0;
      end else begin
         rsel_ff <= ctl.rd_node ? 2'd1 : ctl.rd_left ? 2'd2 : ctl.rd_right ? 2'd3 : 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsel_ff == 2'd1) node_ff  <= rd_v;
      if (rsel_ff == 2'd2) left_ff  <= rd_v;
      if (rsel_ff == 2'd3) right_ff <= rd_v;
      if (ctl.decide)      tgte_ff  <= pick_e;
   end

   // in decide, latest read is still in rd_q
   assign node_v = (rsel_ff == 2'd1) ? rd_v : node_ff;
   assign left_v = (rsel_ff == 2'd2) ? rd_v : left_ff;

   always_comb begin
      logic [EW-1:0] right_v;
      right_v = (rsel_ff == 2'd3) ? rd_v : right_ff;
      pick_e = node_v;
      pick_p = cur_ff;
      if (sts.has_left && left_v[EW-1 -: PRIO_WIDTH] > node_v[EW-1 -: PRIO_WIDTH]) begin
         pick_e = left_v;
         pick_p = lpos[CW-1:0];
      end
      if (sts.has_right && right_v[EW-1 -: PRIO_WIDTH] > pick_e[EW-1 -: PRIO_WIDTH]) begin
         pick_e = right_v;
         pick_p = rpos[CW-1:0];
      end
   end

   assign sts.has_left     = lpos < PW'(n_ff);
   assign sts.has_right    = rpos < PW'(n_ff);
   assign sts.need_swap    = pick_p != cur_ff;
   assign sts.build_done   = build_ff ? (bi_ff == CW'(1)) : 1'b1;
   assign sts.extract_done = n_ff <= CW'(1);
   assign sts.is_sort      = req_data.action == ACT_SORT;
   assign sts.sort_trivial = count_ff < CW'(2);
   assign sts.rsp_busy     = (rsp_valid_ff && rsp_stall) || pop_pend_ff;

   // memory writes: push, sift swap (decide latches the target, then swap writes the target
   // entry at cur and the node at tgt), extract swap
   logic          wr2_ff;
   logic [AW-1:0] wr2_addr_ff;
   logic [EW-1:0] wr2_data_ff;
   logic [EW-1:0] root_ff;
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = slot(head_ff, count_ff);
      wr_data = {req_data.entry_priority, TAG_WIDTH'(req_data.entry_tag)};
      if (ctl.accept && req_data.action == ACT_PUSH && count_ff < CW'(CAPACITY)) begin
         wr_en = 1'b1;
      end else if (ctl.swap_wr) begin
         wr_en = 1'b1; wr_addr = slot(head_ff, cur_ff); wr_data = tgte_ff;
      end else if (ctl.ex_wr) begin
         wr_en = 1'b1; wr_addr = slot(head_ff, '0); wr_data = rd_v;
      end else if (wr2_ff) begin
         wr_en = 1'b1; wr_addr = wr2_addr_ff; wr_data = wr2_data_ff;
      end
   end

   // second write of each swap is registered in wr2 and goes while the next node is read;
   // after a sift swap that read hits the same slot and takes the forwarded entry
   always_ff @(posedge clock) begin
      if (reset) begin
         wr2_ff <= 1'b0;
      end else begin
         wr2_ff <= ctl.swap_wr | ctl.ex_wr;
      end
      if (ctl.swap_wr) begin
         wr2_addr_ff <= slot(head_ff, tgt_ff);
         wr2_data_ff <= node_ff;
      end else if (ctl.ex_wr) begin
         wr2_addr_ff <= slot(head_ff, n_ff - CW'(1));
         wr2_data_ff <= root_ff;
      end
      if (ctl.ex_rd) root_ff <= rd_v;
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      n_in     = n_ff;
      bi_in    = bi_ff;
      cur_in   = cur_ff;
      tgt_in   = tgt_ff;
      build_in = build_ff;
      if (ctl.accept && req_data.action == ACT_PUSH && count_ff < CW'(CAPACITY))
         count_in = count_ff + CW'(1);
      if (ctl.accept && req_data.action == ACT_POP && count_ff != '0) begin
         head_in  = slot(head_ff, CW'(1));
         count_in = count_ff - CW'(1);
      end
      if (ctl.sort_init) begin
         n_in = count_ff; bi_in = count_ff >> 1; build_in = 1'b1;
      end
      if (ctl.load_root) cur_in = bi_ff - CW'(1);
      if (ctl.decide) tgt_in = pick_p;
      if (ctl.build_next) bi_in = bi_ff - CW'(1);
      if (ctl.decide && !sts.need_swap && sts.build_done) build_in = 1'b0;
      if (ctl.swap_wr) cur_in = tgt_ff;
      if (ctl.ex_wr) begin
         n_in = n_ff - CW'(1); cur_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         build_ff <= 1'b0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         build_ff <= build_in;
      end
      n_ff   <= n_in;
      bi_ff  <= bi_in;
      cur_ff <= cur_in;
      tgt_ff <= tgt_in;
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (ctl.rsp_load) rsp_valid_in = !(ctl.accept && req_data.action == ACT_POP &&
                                         count_ff != '0);
      if (pop_pend_ff) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pop_pend_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         pop_pend_ff  <= ctl.accept && req_data.action == ACT_POP && count_ff != '0;
      end
      if (ctl.rsp_load) begin
         rsp_ff.status       <= ST_OK;
         rsp_ff.out_priority <= '0;
         rsp_ff.out_tag      <= '0;
         rsp_ff.occupancy    <= OCC_WIDTH'(count_in);
         if (ctl.accept && req_data.action == ACT_PUSH && count_ff >= CW'(CAPACITY))
            rsp_ff.status <= ST_FULL;
         if (ctl.accept && req_data.action == ACT_POP && count_ff == '0)
            rsp_ff.status <= ST_EMPTY;
      end
      if (pop_pend_ff) begin
         rsp_ff.out_priority <= rd_v[EW-1 -: PRIO_WIDTH];
         rsp_ff.out_tag      <= rd_v[TAG_WIDTH-1:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[hw/rtl/ring_queue_with_heap_sort_core.sv]
// top level of the ring queue with heap sort
//  channel | direction | handshake         | payload
//  req     | in        | req_valid/stall   | action, entry_priority, entry_tag
//  rsp     | out       | rsp_valid/stall   | status, out_priority, out_tag, occupancy
// push and empty-pop results appear in the cycle after the item is taken; a pop with
// data first reads its entry; a sort builds the heap and then extracts, bounded by
// the entry memory (one read and one write a cycle)
// reset clears head, count and control; memory contents are left undefined
// a stalled result, or a pop still reading its entry, blocks the next item
module ring_queue_with_heap_sort_core #(
   parameter int CAPACITY  = rqhs_pkg::CAPACITY_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rqhs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rqhs_pkg::rsp_type rsp_data
);
   import rqhs_pkg::*;

   ctl_type ctl;
   sts_type sts;

   // sequencer for push, pop and heap sort
   rqhs_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .sts, .ctl
   );

   // storage and sift datapath
   rqhs_dp #(.CAPACITY(CAPACITY)) u_dp (
      .clock, .reset, .req_data, .rsp_stall, .rsp_valid, .rsp_data, .ctl, .sts
   );

endmodule

[hw/rtl/rqhs_checker.sv]
// port-level checker for the ring queue with heap sort
module rqhs_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input rqhs_pkg::rsp_type rsp_data
);
   import rqhs_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == ST_OK || rsp_data.status == ST_FULL ||
                     rsp_data.status == ST_EMPTY))
      else $error("bad status");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.out_tag == '0 &&
      rsp_data.out_priority == '0)
      else $error("nonzero entry on error");

   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("item taken while result stalled");

endmodule

bind ring_queue_with_heap_sort_core rqhs_checker u_rqhs_checker (
   .clock, .reset, .req_stall, .rsp_valid, .rsp_stall, .rsp_data
);
